FILE: hw/rtl/owtfc_pkg.sv
package owtfc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TEMP_W = 14;
   localparam int unsigned WIDE_W = 21;
   localparam int unsigned PROD_W = 40;

   // scratchpad byte positions
   localparam logic [3:0] POS_CRC  = 4'd8;
   localparam logic [3:0] POS_DONE = 4'd9;

   // register indexes
   localparam logic CSR_FAHRENHEIT = 1'b0;
   localparam logic CSR_THRESHOLD  = 1'b1;

   localparam logic [7:0] CRC_POLY      = 8'h8C;
   localparam logic [7:0] THRESH_RESET  = 8'd3;

   // floor(n/5) for n < 2**20 is (n * DIV5_MULT) >> DIV5_SHIFT
   localparam logic [19:0] DIV5_MULT  = 20'd838861;
   localparam int unsigned DIV5_SHIFT = 22;
   // 9t is biased by 5*65536 so the division sees a nonnegative value
   localparam logic signed [WIDE_W-1:0] F_BIAS   = 21'sd327680;
   // removes the bias quotient (65536) and adds the 512 offset
   localparam logic signed [WIDE_W-1:0] F_UNBIAS = 21'sd65024;

   localparam logic signed [WIDE_W-1:0] WIDE_MIN = -21'sd1072;
   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 21'sd4112;

   typedef logic signed [TEMP_W-1:0] temp_type;

   // one byte of the reflected CRC-8, LSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (v[0]) begin
            v = (v >> 1) ^ CRC_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return v;
   endfunction

endpackage

FILE: hw/rtl/owtfc_if.sv
interface owtfc_req_if
   import owtfc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface owtfc_rsp_if
   import owtfc_pkg::*;
();
   logic     valid;
   logic     ready;
   temp_type temperature;
   logic     crc_ok;
   logic     changed;

   modport source (output valid, output temperature, output crc_ok, output changed,
                   input ready);
   modport sink   (input valid, input temperature, input crc_ok, input changed,
                   output ready);
endinterface

FILE: hw/rtl/onewire_temp_frame_checker.sv
// A result for the CRC byte (byte 8) passes stage 1, stage 2 and the output register.
// Throughput: one item per cycle while not stalled by rsp_ch.ready; bytes 0..7 and
// stray bytes only update the frame state, the CRC byte walks a 3-stage decode pipe
// with a 20x20 multiply. Reset (synchronous, active high) clears frame state, report
// history and the pipe valids; fahrenheit_mode resets to 0 and change_threshold to 3.
module onewire_temp_frame_checker
   import owtfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   owtfc_req_if.sink         req_ch,
   owtfc_rsp_if.source       rsp_ch,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [BYTE_W-1:0] csr_wdata
);

   // configuration
   logic       fahr_mode_ff;
   logic [7:0] threshold_ff;

   // frame state
   logic [7:0] crc_ff, crc_in;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] low_ff;
   logic [7:0] high_ff;

   // pipe
   logic                    s1_valid_ff, s1_ok_ff;
   logic signed [15:0]      s1_temp_ff;
   logic                    s2_valid_ff, s2_ok_ff;
   logic signed [15:0]      s2_temp_ff;
   logic [PROD_W-1:0]       s2_prod_ff;
   logic                    rsp_valid_ff, rsp_ok_ff, rsp_changed_ff;
   temp_type                rsp_temp_ff;

   temp_type                last_ff;
   logic                    have_ff;

   logic                    out_ready, s2_ready, s1_ready;
   logic                    req_fire;
   logic [7:0]              crc_eff;
   logic [3:0]              pos_eff;
   logic signed [WIDE_W-1:0] nine_t;
   logic [19:0]             div_arg;
   logic [17:0]             quot;
   logic signed [WIDE_W-1:0] fahr_t, sel_t;
   temp_type                sat_t;
   logic signed [TEMP_W:0]  diff;
   logic [TEMP_W:0]         abs_diff;
   logic                    report;

   assign out_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign s2_ready     = !s2_valid_ff || out_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_ch.ready = s1_ready;
   assign req_fire     = req_ch.valid && s1_ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.temperature = rsp_temp_ff;
   assign rsp_ch.crc_ok      = rsp_ok_ff;
   assign rsp_ch.changed     = rsp_changed_ff;

   // frame start restarts the frame at whatever position we are in
   assign crc_eff = req_ch.frame_start ? 8'd0 : crc_ff;
   assign pos_eff = req_ch.frame_start ? 4'd0 : pos_ff;

   always_comb begin
      crc_in = crc_ff;
      pos_in = pos_ff;
      if (pos_eff < POS_CRC) begin
         crc_in = crc8_byte(crc_eff, req_ch.data_byte);
         pos_in = pos_eff + 4'd1;
      end else if (pos_eff == POS_CRC) begin
         pos_in = POS_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fahr_mode_ff <= 1'b0;
         threshold_ff <= THRESH_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_FAHRENHEIT) begin
            fahr_mode_ff <= csr_wdata[0];
         end else begin
            threshold_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= 8'd0;
         pos_ff  <= 4'd0;
         low_ff  <= 8'd0;
         high_ff <= 8'd0;
      end else if (req_fire) begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         if (pos_eff == 4'd0) begin
            low_ff <= req_ch.data_byte;
         end
         if (pos_eff == 4'd1) begin
            high_ff <= req_ch.data_byte;
         end
      end
   end

   // stage 1: CRC byte captured with the check result
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_fire && (pos_eff == POS_CRC);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ok_ff   <= (crc_eff == req_ch.data_byte);
         s1_temp_ff <= $signed({high_ff, low_ff});
      end
   end

   // stage 2: biased 9t times the reciprocal of 5
   assign nine_t  = ($signed({{5{s1_temp_ff[15]}}, s1_temp_ff}) <<< 3)
                  + $signed({{5{s1_temp_ff[15]}}, s1_temp_ff}) + F_BIAS;
   assign div_arg = nine_t[19:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_ok_ff   <= s1_ok_ff;
         s2_temp_ff <= s1_temp_ff;
         s2_prod_ff <= div_arg * DIV5_MULT;
      end
   end

   // stage 3: scale select, clamp, change test
   assign quot   = s2_prod_ff[DIV5_SHIFT +: 18];
   assign fahr_t = $signed({3'b000, quot}) - F_UNBIAS;
   assign sel_t  = fahr_mode_ff ? fahr_t : $signed({{5{s2_temp_ff[15]}}, s2_temp_ff});

   always_comb begin
      if (sel_t < WIDE_MIN) begin
         sat_t = WIDE_MIN[TEMP_W-1:0];
      end else if (sel_t > WIDE_MAX) begin
         sat_t = WIDE_MAX[TEMP_W-1:0];
      end else begin
         sat_t = sel_t[TEMP_W-1:0];
      end
   end

   assign diff     = $signed({sat_t[TEMP_W-1], sat_t}) - $signed({last_ff[TEMP_W-1], last_ff});
   assign abs_diff = diff[TEMP_W] ? $unsigned(-diff) : $unsigned(diff);
   assign report   = s2_ok_ff && (!have_ff || (abs_diff > {7'd0, threshold_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
         last_ff      <= '0;
      end else if (out_ready) begin
         rsp_valid_ff <= s2_valid_ff;
         if (s2_valid_ff && report) begin
            have_ff <= 1'b1;
            last_ff <= sat_t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_temp_ff    <= s2_ok_ff ? sat_t : '0;
         rsp_ok_ff      <= s2_ok_ff;
         rsp_changed_ff <= report;
      end
   end

endmodule
